// ===== src/stpq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stpq_pkg
// Shared types and constants of the sorted task priority queue.
// ----------------------------------------------------------------------------
package stpq_pkg;
    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int ID_COUNT_DEF    = 256;
    localparam int ID_W            = 9;
    localparam int PRIO_W          = 8;
    localparam int TIME_W          = 32;

    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_LOOKUP = 2'd1,
        FN_POP    = 2'd2,
        FN_NONE   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [TIME_W-1:0] rem;
    } t_entry;

    typedef struct packed {
        t_status           status;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [TIME_W-1:0] rem;
    } t_result;
endpackage
`default_nettype wire

// ===== src/stpq_id_alloc.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stpq_id_alloc
// ID use map in a memory of 32-bit words, swept lowest word first.
// A request scans from a low-water word pointer; found bit is set and the
// lowest free ID reported. Words below the pointer are always full.
// ----------------------------------------------------------------------------
module stpq_id_alloc #(
    parameter int ID_COUNT = stpq_pkg::ID_COUNT_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_req,
    output logic                           o_ready,
    output logic                           o_done,
    output logic                           o_found,
    output logic [stpq_pkg::ID_W-1:0]      o_id
);
    import stpq_pkg::*;
    localparam int WORDS = (ID_COUNT + 31) / 32;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PW    = $clog2(WORDS + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_CHK  = 4'b0100,
        S_WR   = 4'b1000
    } t_state;

    t_state        r_state;
    logic [PW-1:0] r_ptr;
    logic [PW-1:0] r_init;
    logic [31:0]   mem [WORDS];
    logic [31:0]   r_rd;
    logic [31:0]   r_wdata;
    logic          r_wen;

    logic [31:0] valid_mask;
    logic [31:0] free_bits;
    logic [4:0]  fbit;
    logic        any_free;

    assign o_ready = (r_state == S_IDLE) && !r_wen;

    always_comb begin
        valid_mask = '1;
        if (int'(r_ptr) == WORDS - 1 && (ID_COUNT % 32) != 0) begin
            valid_mask = (32'd1 << (ID_COUNT % 32)) - 32'd1;
        end
        free_bits = ~r_rd & valid_mask;
        any_free = |free_bits;
        fbit = '0;
        for (int b = 31; b >= 0; b--) begin
            if (free_bits[b]) fbit = 5'(b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_wen) mem[r_init[AW-1:0]] <= r_wdata;
        if (r_state == S_RD) r_rd <= mem[r_ptr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        o_done <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ptr   <= '0;
            r_init  <= '0;
            r_wen   <= 1'b1;
            r_wdata <= '0;
            o_found <= 1'b0;
        end else begin
            r_wen <= 1'b0;
            if (int'(r_init) < WORDS - 1 && r_state == S_IDLE && r_wen) begin
                r_init <= r_init + 1'b1;
                r_wen  <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: if (i_req && !r_wen) begin
                    if (int'(r_ptr) >= WORDS) begin
                        o_found <= 1'b0;
                        o_done  <= 1'b1;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_RD: r_state <= S_CHK;
                S_CHK: begin
                    if (any_free) begin
                        r_init  <= r_ptr;
                        r_wdata <= r_rd | (32'd1 << fbit);
                        r_wen   <= 1'b1;
                        o_found <= 1'b1;
                        o_id    <= ID_W'(32 * int'(r_ptr) + int'(fbit) + 1);
                        o_done  <= 1'b1;
                        r_state <= S_WR;
                    end else begin
                        r_ptr <= r_ptr + 1'b1;
                        if (int'(r_ptr) + 1 >= WORDS) begin
                            o_found <= 1'b0;
                            o_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_WR: begin
                    if (&r_wdata | (r_wdata == valid_mask)) r_ptr <= r_ptr + 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== src/sorted_task_priority_queue_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_task_priority_queue_top
// Sorted task queue held in a one-port-read memory; insert shifts entries up,
// pop shifts them down, lookup scans from the head.
// ----------------------------------------------------------------------------
// channel  dir  fields (tdata low to high)
// s_axis   in   func[1:0] time_units[33:2] task_priority[41:34] lookup_id[50:42]
// m_axis   out  status[1:0] task_id[10:2] result_priority[18:11] rem_time[50:19]
// An insert first takes an ID from the ID map, then scans for the position and
// shifts, one memory entry read and written per cycle; a pop shifts down and
// a lookup scans from the head. Reset clears the ID map; input is held off
// meanwhile. A stalled result holds in the output register; the next item is
// taken once it drains.
// ----------------------------------------------------------------------------
module sorted_task_priority_queue_top #(
    parameter int QUEUE_DEPTH = stpq_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_COUNT    = stpq_pkg::ID_COUNT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [55:0] s_axis_tdata,  // func, time_units, task_priority, lookup_id
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata   // status, task_id, result_priority, rem_time
);
    import stpq_pkg::*;
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_ALLOC = 7'b0000010,
        S_FIND  = 7'b0000100,
        S_SHUP  = 7'b0001000,
        S_SHDN  = 7'b0010000,
        S_LOOK  = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_idx;
    logic [CW-1:0]   r_pos;
    logic            r_pend;
    t_entry          r_new;
    logic [ID_W-1:0] r_lid;
    t_result         r_res;
    logic            r_req;

    t_entry          mem [QUEUE_DEPTH];
    t_entry          r_rd;
    logic [AW-1:0]   rd_addr;
    logic            rd_en;
    logic [AW-1:0]   wr_addr;
    logic            wr_en;
    t_entry          wr_data;

    logic            a_ready, a_done, a_found;
    logic [ID_W-1:0] a_id;

    stpq_id_alloc #(.ID_COUNT(ID_COUNT)) u_alloc (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(r_req), .o_ready(a_ready),
        .o_done(a_done), .o_found(a_found), .o_id(a_id)
    );

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) r_rd <= mem[rd_addr];
    end

    logic goes_first;
    always_comb begin
        if (r_rd.prio != r_new.prio) goes_first = r_rd.prio < r_new.prio;
        else if (r_rd.rem != r_new.rem) goes_first = r_new.rem < r_rd.rem;
        else goes_first = r_rd.id > r_new.id;
    end

    logic in_acc;
    assign s_axis_tready = (r_state == S_IDLE) && !m_axis_tvalid && a_ready;
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // read address / write control
    always_comb begin
        rd_en = 1'b0; rd_addr = '0; wr_en = 1'b0; wr_addr = '0; wr_data = r_rd;
        unique case (r_state)
            S_FIND: begin
                rd_en = 1'b1; rd_addr = r_idx[AW-1:0];
            end
            S_SHUP: begin
                // r_idx is the slot being written; prime with idx-1, then read idx-2 ahead
                if (r_pend) begin
                    wr_en = 1'b1; wr_addr = r_idx[AW-1:0];
                end
                rd_en = 1'b1;
                rd_addr = r_pend ? AW'(r_idx - 2'd2) : AW'(r_idx - 1'b1);
            end
            S_SHDN: begin
                rd_en = 1'b1; rd_addr = AW'(r_idx);
                if (r_pend && r_idx > CW'(1)) begin
                    wr_en = 1'b1; wr_addr = AW'(r_idx - 2'd2);
                end
            end
            S_LOOK: begin
                rd_en = 1'b1; rd_addr = r_idx[AW-1:0];
            end
            default: ;
        endcase
        if (r_state == S_SHUP && r_pend && r_idx == r_pos) wr_data = r_new;
    end

    always_ff @(posedge i_clk) begin
        r_req <= 1'b0;
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_count       <= '0;
            m_axis_tvalid <= 1'b0;
            r_pend        <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (in_acc) begin
                    r_new.rem  <= s_axis_tdata[33:2];
                    r_new.prio <= s_axis_tdata[41:34];
                    r_lid      <= s_axis_tdata[50:42];
                    r_idx      <= '0;
                    r_pend     <= 1'b0;
                    r_res      <= '{ST_NOT_FOUND, '0, '0, '0};
                    unique case (t_func'(s_axis_tdata[1:0]))
                        FN_INSERT: begin
                            if (int'(r_count) >= QUEUE_DEPTH) begin
                                r_res   <= '{ST_FULL, '0, '0, '0};
                                r_state <= S_OUT;
                            end else begin
                                r_req   <= 1'b1;
                                r_state <= S_ALLOC;
                            end
                        end
                        FN_LOOKUP: r_state <= (r_count == 0) ? S_OUT : S_LOOK;
                        FN_POP: begin
                            if (r_count == 0) begin
                                r_res   <= '{ST_EMPTY, '0, '0, '0};
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_SHDN;
                            end
                        end
                        default: r_state <= S_OUT;
                    endcase
                end
                S_ALLOC: if (a_done) begin
                    if (!a_found) begin
                        r_res   <= '{ST_FULL, '0, '0, '0};
                        r_state <= S_OUT;
                    end else begin
                        r_new.id <= a_id;
                        r_res    <= '{ST_OK, a_id, r_new.prio, r_new.rem};
                        r_state  <= (r_count == 0) ? S_SHUP : S_FIND;
                        r_pos    <= '0;
                        r_idx    <= '0;
                        if (r_count == 0) r_pend <= 1'b1;
                    end
                end
                S_FIND: begin
                    // r_pend: a read from r_idx-1 is in r_rd
                    r_pend <= 1'b1;
                    if (r_pend && goes_first) begin
                        r_pos   <= r_idx - 1'b1;
                        r_idx   <= r_count;
                        r_pend  <= 1'b0;
                        r_state <= S_SHUP;
                    end else if (r_pend && r_idx == r_count) begin
                        r_pos   <= r_count;
                        r_idx   <= r_count;
                        r_state <= S_SHUP;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_SHUP: begin
                    // writes slot r_idx from r_rd (slot r_idx-1), new entry at r_pos
                    if (r_pend && r_idx == r_pos) begin
                        r_count <= r_count + 1'b1;
                        r_state <= S_OUT;
                    end else if (!r_pend) begin
                        r_pend <= 1'b1;
                        r_idx  <= r_idx;
                    end else begin
                        r_idx <= r_idx - 1'b1;
                    end
                end
                S_SHDN: begin
                    if (r_pend && r_idx == 1) begin
                        r_res <= '{ST_OK, r_rd.id, r_rd.prio, r_rd.rem};
                    end
                    r_pend <= 1'b1;
                    if (r_idx == r_count) begin
                        r_count <= r_count - 1'b1;
                        r_state <= S_OUT;
                        if (r_count == 1) r_res <= '{ST_OK, r_rd.id, r_rd.prio, r_rd.rem};
                    end
                    r_idx <= r_idx + 1'b1;
                end
                S_LOOK: begin
                    r_pend <= 1'b1;
                    if (r_pend && r_rd.id == r_lid) begin
                        r_res   <= '{ST_OK, r_rd.id, r_rd.prio, r_rd.rem};
                        r_state <= S_OUT;
                    end else if (r_idx == r_count) begin
                        r_state <= S_OUT;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_OUT: begin
                    m_axis_tvalid <= 1'b1;
                    m_axis_tdata  <= {5'd0, r_res.rem, r_res.prio, r_res.id, r_res.status};
                    r_state       <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= QUEUE_DEPTH)
        else $error("entry count overflow");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !s_axis_tready)
        else $error("accepted while busy");
endmodule
`default_nettype wire
